@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the capture frequency meter RTL.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CFM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cfm assertion failed");
`define CFM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("cfm assertion failed");
`else
`define CFM_ASSERT(label, clk, rst_n, prop)
`define CFM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ hw/rtl/cfm_pkg.sv @@
// Types and constants of the capture frequency meter.
// No dependencies.
package cfm_pkg;

    localparam int CAP_W      = 16;
    localparam int RATE_W     = 24;
    localparam int FREQ_W     = 16;
    localparam int DIGIT_W    = 6;
    localparam int NUM_DIGITS = 5;
    localparam int BCD_W      = 4 * NUM_DIGITS;

    localparam logic [RATE_W-1:0]  RATE_RESET = 24'd1000000;
    localparam logic [FREQ_W-1:0]  FREQ_MAX   = 16'hFFFF;
    localparam logic [DIGIT_W-1:0] ASCII_ZERO = 6'h30;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_BCD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              done;
        logic              sat;
        logic [FREQ_W-1:0] quot;
    } t_div_res;

    typedef struct packed {
        logic                           done;
        logic [NUM_DIGITS-1:0][3:0]     digits;
    } t_bcd_res;

endpackage

@@ hw/rtl/cfm_if.sv @@
// Handshake channels of the capture frequency meter: capture, result, config.
// Depends on cfm_pkg.
interface cfm_cap_if;
    logic                      valid;
    logic                      ready;
    logic [cfm_pkg::CAP_W-1:0] capture_time;
    modport source (output valid, output capture_time, input ready);
    modport sink   (input valid, input capture_time, output ready);
endinterface

interface cfm_res_if;
    logic                        valid;
    logic                        ready;
    logic [cfm_pkg::FREQ_W-1:0]  frequency;
    logic                        saturated;
    logic [cfm_pkg::DIGIT_W-1:0] digit_ten_thousands;
    logic [cfm_pkg::DIGIT_W-1:0] digit_thousands;
    logic [cfm_pkg::DIGIT_W-1:0] digit_hundreds;
    logic [cfm_pkg::DIGIT_W-1:0] digit_tens;
    logic [cfm_pkg::DIGIT_W-1:0] digit_units;
    modport source (output valid, output frequency, output saturated,
                    output digit_ten_thousands, output digit_thousands,
                    output digit_hundreds, output digit_tens, output digit_units,
                    input ready);
    modport sink   (input valid, input frequency, input saturated,
                    input digit_ten_thousands, input digit_thousands,
                    input digit_hundreds, input digit_tens, input digit_units,
                    output ready);
endinterface

interface cfm_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [cfm_pkg::RATE_W-1:0] tick_rate;
    modport source (output valid, output tick_rate, input ready);
    modport sink   (input valid, input tick_rate, output ready);
endinterface

@@ hw/rtl/cfm_div.sv @@
// Bit-serial restoring divider: 24-bit dividend by 16-bit divisor, one
// quotient bit per cycle. Depends on cfm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cfm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [cfm_pkg::RATE_W-1:0] i_dividend,
    input  logic [cfm_pkg::CAP_W-1:0]  i_divisor,
    output cfm_pkg::t_div_res          o_res
);
    localparam int STEPS = cfm_pkg::RATE_W;
    localparam int CNT_W = $clog2(STEPS);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [cfm_pkg::RATE_W-1:0] r_num;
    logic [cfm_pkg::CAP_W-1:0]  r_rem;
    logic [cfm_pkg::CAP_W-1:0]  r_den;

    logic [cfm_pkg::CAP_W:0]    w_rem_sh;
    logic [cfm_pkg::CAP_W:0]    w_diff;
    logic                       w_ge;

    assign w_rem_sh = {r_rem, r_num[cfm_pkg::RATE_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_den};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[cfm_pkg::RATE_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[cfm_pkg::CAP_W-1:0] : w_rem_sh[cfm_pkg::CAP_W-1:0];
        end
    end

    assign o_res.done = r_done;
    assign o_res.sat  = |r_num[cfm_pkg::RATE_W-1:cfm_pkg::FREQ_W];
    assign o_res.quot = r_num[cfm_pkg::FREQ_W-1:0];

    `CFM_ASSERT(a_div_done_after_busy, i_clk, i_rst_n, r_done |-> $past(r_busy))
    `CFM_ASSERT(a_div_no_restart, i_clk, i_rst_n, r_busy && !i_start |=> r_busy || r_done)
    `CFM_ASSERT(a_div_rem_bound, i_clk, i_rst_n, r_busy && !i_start |=> r_rem < r_den)

endmodule

@@ hw/rtl/cfm_bcd.sv @@
// Bit-serial binary to BCD converter (shift and add 3), one bit per cycle.
// Depends on cfm_pkg.
module cfm_bcd (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [cfm_pkg::FREQ_W-1:0] i_bin,
    output cfm_pkg::t_bcd_res          o_res
);
    localparam int STEPS = cfm_pkg::FREQ_W;
    localparam int CNT_W = $clog2(STEPS);

    logic                                r_busy;
    logic                                r_done;
    logic [CNT_W-1:0]                    r_cnt;
    logic [cfm_pkg::FREQ_W-1:0]          r_bin;
    logic [cfm_pkg::NUM_DIGITS-1:0][3:0] r_bcd;
    logic [cfm_pkg::NUM_DIGITS-1:0][3:0] w_adj;
    logic [cfm_pkg::BCD_W-1:0]           w_adj_flat;

    always_comb begin
        for (int i = 0; i < cfm_pkg::NUM_DIGITS; i++) begin
            w_adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
    end

    assign w_adj_flat = w_adj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_bin;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[cfm_pkg::FREQ_W-2:0], 1'b0};
            r_bcd <= {w_adj_flat[cfm_pkg::BCD_W-2:0], r_bin[cfm_pkg::FREQ_W-1]};
        end
    end

    assign o_res.done   = r_done;
    assign o_res.digits = r_bcd;

endmodule

@@ hw/rtl/capture_frequency_meter_top.sv @@
// Capture frequency meter: pairs timer captures, divides tick_rate by the
// period with a serial divider and converts the frequency to ASCII digits.
// The second capture beat starts the divide; its quotient, or FREQ_MAX on
// saturation, then goes through the BCD shift before the result is loaded.
// A zero period skips the divide. Input is held off until the result is
// loaded. Reset: sync active low, tick_rate 1000000.
`include "assert_macros.svh"

module capture_frequency_meter_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cfm_cap_if.sink    i_cap,
    cfm_cfg_if.sink    i_cfg,
    cfm_res_if.source  o_res
);
    cfm_pkg::t_state             r_state, n_state;
    logic                        r_pending;
    logic [cfm_pkg::CAP_W-1:0]   r_first;
    logic [cfm_pkg::RATE_W-1:0]  r_tick_rate;
    logic [cfm_pkg::FREQ_W-1:0]  r_freq;
    logic                        r_sat;

    logic                        r_res_valid;
    logic [cfm_pkg::FREQ_W-1:0]  r_res_freq;
    logic                        r_res_sat;
    logic [cfm_pkg::NUM_DIGITS-1:0][cfm_pkg::DIGIT_W-1:0] r_res_dig;

    logic                        w_cap_beat;
    logic [cfm_pkg::CAP_W-1:0]   w_period;
    logic                        w_div_start;
    logic                        w_bcd_start;
    logic                        w_zero_start;
    logic                        w_load;
    logic [cfm_pkg::FREQ_W-1:0]  w_bcd_in;
    cfm_pkg::t_div_res           w_div;
    cfm_pkg::t_bcd_res           w_bcd;

    assign i_cfg.ready = 1'b1;
    assign i_cap.ready = (r_state == cfm_pkg::ST_IDLE);
    assign w_cap_beat  = i_cap.valid && i_cap.ready;
    assign w_period    = i_cap.capture_time - r_first;
    assign w_zero_start = w_cap_beat && r_pending && (w_period == '0);
    assign w_div_start  = w_cap_beat && r_pending && (w_period != '0);

    always_comb begin
        n_state     = r_state;
        w_bcd_start = 1'b0;
        w_load      = 1'b0;
        w_bcd_in    = w_div.sat ? cfm_pkg::FREQ_MAX : w_div.quot;
        case (r_state)
            cfm_pkg::ST_IDLE: begin
                if (w_zero_start) begin
                    w_bcd_start = 1'b1;
                    w_bcd_in    = cfm_pkg::FREQ_MAX;
                    n_state     = cfm_pkg::ST_BCD;
                end else if (w_div_start) begin
                    n_state = cfm_pkg::ST_DIV;
                end
            end
            cfm_pkg::ST_DIV: begin
                if (w_div.done) begin
                    w_bcd_start = 1'b1;
                    n_state     = cfm_pkg::ST_BCD;
                end
            end
            cfm_pkg::ST_BCD: begin
                if (w_bcd.done) begin
                    n_state = cfm_pkg::ST_DONE;
                end
            end
            cfm_pkg::ST_DONE: begin
                if (!r_res_valid || o_res.ready) begin
                    w_load  = 1'b1;
                    n_state = cfm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cfm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfm_pkg::ST_IDLE;
            r_pending   <= 1'b0;
            r_first     <= '0;
            r_tick_rate <= cfm_pkg::RATE_RESET;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_tick_rate <= i_cfg.tick_rate;
            end
            if (w_cap_beat) begin
                r_pending <= !r_pending;
                if (!r_pending) begin
                    r_first <= i_cap.capture_time;
                end
            end
            if (w_load) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_bcd_start) begin
            r_freq <= w_bcd_in;
            r_sat  <= w_zero_start || w_div.sat;
        end
        if (w_load) begin
            r_res_freq <= r_freq;
            r_res_sat  <= r_sat;
            for (int i = 0; i < cfm_pkg::NUM_DIGITS; i++) begin
                r_res_dig[i] <= cfm_pkg::ASCII_ZERO + {2'b00, w_bcd.digits[i]};
            end
        end
    end

    cfm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_tick_rate),
        .i_divisor  (w_period),
        .o_res      (w_div)
    );

    cfm_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bcd_start),
        .i_bin   (w_bcd_in),
        .o_res   (w_bcd)
    );

    assign o_res.valid               = r_res_valid;
    assign o_res.frequency           = r_res_freq;
    assign o_res.saturated           = r_res_sat;
    assign o_res.digit_ten_thousands = r_res_dig[4];
    assign o_res.digit_thousands     = r_res_dig[3];
    assign o_res.digit_hundreds      = r_res_dig[2];
    assign o_res.digit_tens          = r_res_dig[1];
    assign o_res.digit_units         = r_res_dig[0];

    `CFM_ASSERT(a_sat_is_max, i_clk, i_rst_n, r_res_valid && r_res_sat |-> r_res_freq == cfm_pkg::FREQ_MAX)
    `CFM_ASSERT(a_div_only_on_second, i_clk, i_rst_n, w_div_start |-> r_pending && r_state == cfm_pkg::ST_IDLE)
    `CFM_ASSERT(a_load_from_done, i_clk, i_rst_n, w_load |=> r_res_valid && r_state == cfm_pkg::ST_IDLE)
    `CFM_ASSERT(a_bcd_done_in_bcd, i_clk, i_rst_n, w_bcd.done |-> r_state == cfm_pkg::ST_BCD)

endmodule

@@ tb/capture_frequency_meter_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench of capture_frequency_meter_top: drives capture pairs and tick_rate writes,
// predicts each frequency reading and checks it field by field in a scoreboard class.
// Depends on cfm_pkg, the cfm_*_if interfaces and the RTL of the block.
module capture_frequency_meter_top_tb;
    localparam int CAP_W      = cfm_pkg::CAP_W;
    localparam int RATE_W     = cfm_pkg::RATE_W;
    localparam int FREQ_W     = cfm_pkg::FREQ_W;
    localparam int DIGIT_W    = cfm_pkg::DIGIT_W;
    localparam int NUM_DIGITS = cfm_pkg::NUM_DIGITS;

    localparam logic [RATE_W-1:0]  RATE_RESET = cfm_pkg::RATE_RESET;
    localparam logic [FREQ_W-1:0]  FREQ_MAX   = cfm_pkg::FREQ_MAX;
    localparam logic [DIGIT_W-1:0] ASCII_ZERO = cfm_pkg::ASCII_ZERO;

    typedef struct packed {
        logic [FREQ_W-1:0]                    frequency;
        logic                                 saturated;
        logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   ascii;   // [0] units .. [4] ten thousands
    } t_freq_reading;

    class t_freq_meter_scoreboard;
        logic [RATE_W-1:0] tick_rate;
        bit                awaiting_second;
        logic [CAP_W-1:0]  first_cap;
        t_freq_reading     readings_due[$];
        int                errors;
        int                captures;
        int                readings;
        int                saturations;

        function new();
            tick_rate       = RATE_RESET;
            awaiting_second = 1'b0;
            first_cap       = '0;
            errors          = 0;
            captures        = 0;
            readings        = 0;
            saturations     = 0;
        endfunction

        function void set_rate(logic [RATE_W-1:0] rate);
            tick_rate = rate;
        endfunction

        function int pending();
            return readings_due.size();
        endfunction

        function void note_capture(logic [CAP_W-1:0] cap);
            logic [CAP_W-1:0]  period;
            logic [31:0]       quot;
            logic [FREQ_W-1:0] val;
            t_freq_reading     want;
            captures++;
            if (!awaiting_second) begin
                first_cap       = cap;
                awaiting_second = 1'b1;
                return;
            end
            awaiting_second = 1'b0;
            period = cap - first_cap;
            if (period == '0) begin
                want.frequency = FREQ_MAX;
                want.saturated = 1'b1;
            end else begin
                quot = 32'(tick_rate) / 32'(period);
                if (quot > 32'(FREQ_MAX)) begin
                    want.frequency = FREQ_MAX;
                    want.saturated = 1'b1;
                end else begin
                    want.frequency = quot[FREQ_W-1:0];
                    want.saturated = 1'b0;
                end
            end
            val = want.frequency;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                want.ascii[i] = ASCII_ZERO + DIGIT_W'(val % 10);
                val = val / 10;
            end
            readings_due.push_back(want);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_reading(t_freq_reading got);
            t_freq_reading want;
            string         place [NUM_DIGITS];
            place = '{"units", "tens", "hundreds", "thousands", "ten_thousands"};
            if (readings_due.size() == 0) begin
                report_mismatch("unexpected reading, frequency", got.frequency, -1);
                return;
            end
            want = readings_due.pop_front();
            readings++;
            if (want.saturated) saturations++;
            if (got.frequency !== want.frequency)
                report_mismatch("frequency", got.frequency, want.frequency);
            if (got.saturated !== want.saturated)
                report_mismatch("saturated", got.saturated, want.saturated);
            for (int i = 0; i < NUM_DIGITS; i++) begin
                if (got.ascii[i] !== want.ascii[i])
                    report_mismatch({"digit_", place[i]}, got.ascii[i], want.ascii[i]);
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    cfm_cap_if cap_ch ();
    cfm_cfg_if cfg_ch ();
    cfm_res_if res_ch ();

    capture_frequency_meter_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cap   (cap_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    t_freq_meter_scoreboard sb = new();

    int tx_idle_pct = 12;
    int rx_idle_pct = 49;
    int rx_hold     = 0;
    int rates_used  = 1;

    always #2 clk = ~clk;

    // sender: leaves valid high after an accepted beat; release_capture drops it
    task automatic send_capture(input logic [CAP_W-1:0] cap);
        if ($urandom_range(99) < tx_idle_pct) begin
            cap_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        cap_ch.valid        <= 1'b1;
        cap_ch.capture_time <= cap;
        do @(posedge clk); while (!cap_ch.ready);
        sb.note_capture(cap);
    endtask

    task automatic release_capture();
        cap_ch.valid <= 1'b0;
    endtask

    task automatic send_pair(input logic [CAP_W-1:0] first, input logic [CAP_W-1:0] second);
        send_capture(first);
        send_capture(second);
    endtask

    task automatic wait_quiet();
        release_capture();
        while (sb.pending() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] rate);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.tick_rate <= rate;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.set_rate(rate);
        rates_used++;
    endtask

    // receiver: one ready update per edge, long holds counted here
    initial begin : result_sink
        t_freq_reading got;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready) begin
                got.frequency = res_ch.frequency;
                got.saturated = res_ch.saturated;
                got.ascii     = {res_ch.digit_ten_thousands, res_ch.digit_thousands,
                                 res_ch.digit_hundreds, res_ch.digit_tens,
                                 res_ch.digit_units};
                sb.check_reading(got);
            end
            if (rx_hold > 0) begin
                rx_hold--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : stimulus
        int unsigned      rate_plan [6];
        logic [CAP_W-1:0] first;
        int unsigned      period;
        int unsigned      kind;
        cap_ch.valid        <= 1'b0;
        cap_ch.capture_time <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.tick_rate    <= '0;
        rst_n               <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pairs at the reset tick rate
        send_pair(16'd0, 16'd0);            // zero period
        send_pair(16'd100, 16'd101);        // quotient far too large
        send_pair(16'd0, 16'hFFFF);         // longest period
        send_pair(16'hFFFF, 16'd0);         // wrap, period one
        send_pair(16'd65000, 16'd100);      // wrap
        send_pair(16'd0, 16'd15);           // just above saturation
        send_pair(16'd0, 16'd16);           // just below saturation
        send_pair(16'hAAAA, 16'h5555);
        send_pair(16'h5555, 16'hAAAA);
        send_pair(16'd1234, 16'd1334);      // exactly 10000

        rate_plan[0] = 24'hFFFFFF;
        rate_plan[1] = 1;
        rate_plan[2] = 65536;
        rate_plan[3] = 1000000;
        rate_plan[4] = $urandom_range(1, 24'hFFFFFF);
        rate_plan[5] = 3000000;

        for (int ph = 0; ph < 6; ph++) begin
            wait_quiet();
            write_rate(RATE_W'(rate_plan[ph]));
            tx_idle_pct = (ph < 2) ? 12 : (ph < 4) ? 49 : 0;
            rx_idle_pct = (ph < 2) ? 49 : (ph < 4) ? 12 : 0;
            if (ph == 1) rx_hold = 400;
            for (int n = 0; n < 100; n++) begin
                if (ph == 3 && n == 50) begin
                    release_capture();
                    while (sb.pending() != 0) @(posedge clk);
                end
                first = CAP_W'($urandom);
                kind  = $urandom_range(9);
                case (kind)
                    0: period = 0;
                    1: period = $urandom_range(1, 20);
                    2, 3: period = $urandom_range(0, 16'hFFFF);
                    4: begin
                        period = rate_plan[ph] / 65535 + $urandom_range(0, 2);
                        if (period == 0) period = 1;
                        if (period > 16'hFFFF) period = 16'hFFFF;
                    end
                    5: begin
                        first  = CAP_W'(16'hFFFF - $urandom_range(0, 300));
                        period = $urandom_range(1, 1000);
                    end
                    default: period = $urandom_range(1, 4000);
                endcase
                send_pair(first, first + CAP_W'(period));
            end
        end

        release_capture();
        while (sb.pending() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        $display("Covered %0d captures, %0d readings checked (%0d saturated), %0d tick rates,",
                 sb.captures, sb.readings, sb.saturations, rates_used);
        $display("with idle, backpressure, long hold and pause phases.");
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("Timeout with %0d readings outstanding", sb.pending());
        $display("Test completed with failures");
        $finish;
    end

endmodule
